// ----- hw/rtl/usv_pkg.sv -----
// Shared types and constants for the UTF-8 safe-token validator.
// Used by usv_token_check and utf8_safe_token_validator; depends on nothing.

package usv_pkg;

   localparam int LenWidth   = 13;
   localparam int CpWidth    = 21;
   localparam int ByteWidth  = 8;
   localparam int CodeWidth  = 3;

   localparam logic [LenWidth-1:0] LIMIT_CAP = 13'd4096;
   localparam logic [CpWidth-1:0]  MAX_CODE_POINT = 21'h10ffff;
   localparam logic [CpWidth-1:0]  SURR_LOW  = 21'h00d800;
   localparam logic [CpWidth-1:0]  SURR_HIGH = 21'h00dfff;
   localparam logic [CpWidth-1:0]  MIN_KIND0 = 21'h000080;
   localparam logic [CpWidth-1:0]  MIN_KIND1 = 21'h000800;
   localparam logic [CpWidth-1:0]  MIN_KIND2 = 21'h010000;
   localparam logic [ByteWidth-1:0] CTRL_LIMIT = 8'h20;
   localparam logic [ByteWidth-1:0] DEL_BYTE   = 8'h7f;
   localparam logic [LenWidth-1:0] LIMIT_RESET = 13'd256;

   localparam logic [CodeWidth-1:0] REASON_OK    = 3'd0;
   localparam logic [CodeWidth-1:0] REASON_EMPTY = 3'd1;
   localparam logic [CodeWidth-1:0] REASON_LONG  = 3'd2;
   localparam logic [CodeWidth-1:0] REASON_UTF8  = 3'd3;
   localparam logic [CodeWidth-1:0] REASON_CTRL  = 3'd4;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 last_byte;
      logic                 empty_token;
   } item_type;

   typedef struct packed {
      logic                 token_ok;
      logic [CodeWidth-1:0] fail_reason;
      logic [LenWidth-1:0]  token_length;
   } result_type;

endpackage

// ----- hw/rtl/usv_token_check.sv -----
// Per-token state and its update for each request byte.
// Depends on usv_pkg for the item and result types and the code constants.

module usv_token_check
   import usv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [LenWidth-1:0] limit_cfg,
   input  logic                step,
   input  item_type            item,
   output logic                has_result,
   output result_type          result
);

   logic [LenWidth-1:0] count_ff, count_in;
   logic [1:0]          cont_ff, cont_in;
   logic [CpWidth-1:0]  cp_ff, cp_in;
   logic [1:0]          kind_ff, kind_in;
   logic                enc_err_ff, enc_err_in;
   logic                ctrl_ff, ctrl_in;

   logic [LenWidth-1:0] limit;
   logic [LenWidth-1:0] limit_p1;
   logic [CpWidth-1:0]  cp_shift;
   logic [CpWidth-1:0]  cp_min;
   logic [1:0]          cont_dec;
   logic [LenWidth-1:0] count_upd;
   logic                ctrl_upd;
   logic                err_upd;
   logic [CodeWidth-1:0] reason;
   logic [ByteWidth-1:0] b;

   assign b        = item.data_byte;
   assign limit    = (limit_cfg > LIMIT_CAP) ? LIMIT_CAP : limit_cfg;
   assign limit_p1 = limit + 13'd1;
   assign cp_shift = {cp_ff[CpWidth-7:0], b[5:0]};
   assign cont_dec = cont_ff - 2'd1;

   always_comb begin
      case (kind_ff)
         2'd0:    cp_min = MIN_KIND0;
         2'd1:    cp_min = MIN_KIND1;
         default: cp_min = MIN_KIND2;
      endcase
   end

   always_comb begin
      count_upd = (count_ff < limit_p1) ? count_ff + 13'd1 : count_ff;
      ctrl_upd  = ctrl_ff | (b < CTRL_LIMIT) | (b == DEL_BYTE);
      cont_in   = cont_ff;
      cp_in     = cp_ff;
      kind_in   = kind_ff;
      err_upd   = enc_err_ff;

      // Once an encoding error is seen, later bytes are not decoded.
      if (!enc_err_ff) begin
         if (cont_ff != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               err_upd = 1'b1;
               cont_in = 2'd0;
            end else begin
               cp_in   = cp_shift;
               cont_in = cont_dec;
               if (cont_dec == 2'd0) begin
                  if (cp_shift < cp_min || cp_shift > MAX_CODE_POINT ||
                      (cp_shift inside {[SURR_LOW:SURR_HIGH]})) begin
                     err_upd = 1'b1;
                  end
               end
            end
         end else if (b[7] == 1'b0) begin
            err_upd = 1'b0;
         end else if (b[7:5] == 3'b110) begin
            cont_in = 2'd1;
            cp_in   = {16'd0, b[4:0]};
            kind_in = 2'd0;
         end else if (b[7:4] == 4'b1110) begin
            cont_in = 2'd2;
            cp_in   = {17'd0, b[3:0]};
            kind_in = 2'd1;
         end else if (b[7:3] == 5'b11110) begin
            cont_in = 2'd3;
            cp_in   = {18'd0, b[2:0]};
            kind_in = 2'd2;
         end else begin
            err_upd = 1'b1;
         end
      end

      // A sequence still open at the final byte is truncated.
      if (item.last_byte && cont_in != 2'd0) begin
         err_upd = 1'b1;
      end

      if (count_upd > limit) begin
         reason = REASON_LONG;
      end else if (err_upd) begin
         reason = REASON_UTF8;
      end else if (ctrl_upd) begin
         reason = REASON_CTRL;
      end else begin
         reason = REASON_OK;
      end

      count_in   = count_upd;
      enc_err_in = err_upd;
      ctrl_in    = ctrl_upd;

      has_result = item.empty_token | item.last_byte;
      if (item.empty_token) begin
         result.token_ok     = 1'b0;
         result.fail_reason  = REASON_EMPTY;
         result.token_length = '0;
      end else begin
         result.token_ok     = (reason == REASON_OK);
         result.fail_reason  = reason;
         result.token_length = count_upd;
      end

      // The end of any token returns all per-token state to its reset value.
      if (has_result) begin
         count_in   = '0;
         cont_in    = 2'd0;
         cp_in      = '0;
         kind_in    = 2'd0;
         enc_err_in = 1'b0;
         ctrl_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cont_ff    <= 2'd0;
         cp_ff      <= '0;
         kind_ff    <= 2'd0;
         enc_err_ff <= 1'b0;
         ctrl_ff    <= 1'b0;
      end else if (step) begin
         count_ff   <= count_in;
         cont_ff    <= cont_in;
         cp_ff      <= cp_in;
         kind_ff    <= kind_in;
         enc_err_ff <= enc_err_in;
         ctrl_ff    <= ctrl_in;
      end
   end

endmodule

// ----- hw/rtl/utf8_safe_token_validator.sv -----
// UTF-8 safe-token validator, top level: input and result registers, limit register.
// Depends on usv_pkg and usv_token_check.
//
// A token enters one byte per request on the req_ channel; req_tlast marks the
// final byte and req_tuser marks a request that carries no byte and ends an
// empty token. At the end of every token one response leaves on the rsp_
// channel with the pass flag, the failing reason of highest priority (length,
// then encoding, then control bytes) and the byte count. A request is first
// held in an input register; when it is stepped, the token state is updated
// and any response is loaded into the result register, which drives the rsp_
// channel. One request is accepted every cycle while the block does not stall.
// Requests that end no token keep moving while a response waits, and the
// block stalls the request side only when a finished response has not been
// taken and another token ends. Reset clears the token state, empties both
// registers and sets the length limit to 256. The limit is written through
// csr_we and csr_wdata; the user must do so only while no token is in
// progress, as the block itself does not enforce this.

module utf8_safe_token_validator
   import usv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [LenWidth-1:0] csr_wdata,     // max_token_bytes
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,     // [7:0] data_byte
   input  logic                req_tlast,     // last_byte
   input  logic                req_tuser,     // empty_token
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata      // [0] token_ok, [3:1] fail_reason,
                                              // [16:4] token_length, [23:17] zero
);

   logic [LenWidth-1:0] limit_ff;
   logic                in_valid_ff;
   item_type            in_item_ff;
   logic                out_valid_ff;
   result_type          out_ff;

   logic       has_result;
   result_type result;
   logic       step;
   logic       out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!has_result || out_free);
   assign req_tready = !in_valid_ff || step;

   usv_token_check u_check (
      .clock      (clock),
      .reset      (reset),
      .limit_cfg  (limit_ff),
      .step       (step),
      .item       (in_item_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.data_byte   <= req_tdata;
         in_item_ff.last_byte   <= req_tlast;
         in_item_ff.empty_token <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.token_length, out_ff.fail_reason, out_ff.token_ok};

endmodule
